// File: sv/rlfp_pkg.sv
// ----------------------------------------------------------------------------
// rlfp_pkg
// Types and constants shared by the latest-frame pool modules.
// ----------------------------------------------------------------------------
package rlfp_pkg;

	localparam int SLOT_W = 3;
	localparam int LEN_W  = 24;
	localparam int SEQ_W  = 32;
	localparam int CNT_W  = 8;
	localparam int CFG_W  = 4;
	localparam int CMP_W  = 8;
	localparam int REQ_W  = 61;
	localparam int RES_W  = 125;

	localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;
	localparam logic [CMP_W-1:0] MIN_SLOTS   = 8'd2;
	localparam logic [CFG_W-1:0] SLOTS_RESET = 4'd8;

	typedef enum logic [1:0] {
		ACT_ACQ_WR     = 2'd0,
		ACT_PUBLISH    = 2'd1,
		ACT_ACQ_LATEST = 2'd2,
		ACT_RELEASE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NONE     = 2'd1,
		STAT_BAD_SLOT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_PUB_WR,
		S_PUB_RD_PREV,
		S_PUB_DEC,
		S_LAT_WR,
		S_REL_WR,
		S_DONE
	} ctrl_state_t;

	// first field in the highest bits
	typedef struct packed {
		logic [SEQ_W-1:0]  reader_last_seq;
		logic [LEN_W-1:0]  frame_length;
		logic [SLOT_W-1:0] slot;
		action_t           action;
	} req_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  drop_count;
		logic [SEQ_W-1:0]  total_seq;
		logic [LEN_W-1:0]  granted_length;
		logic [SEQ_W-1:0]  granted_seq;
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
	} result_t;

endpackage

// File: sv/rlfp_ram.sv
// ----------------------------------------------------------------------------
// rlfp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/rlfp_store.sv
// ----------------------------------------------------------------------------
// rlfp_store
// Slot table: one RAM row per slot holding count, sequence and length, with
// a valid bit per row so that rows never written read as zero after reset.
// ----------------------------------------------------------------------------
module rlfp_store #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [DEPTH-1:0] vld_q;
	logic             vld_s1;
	logic [WIDTH-1:0] ram_data;

	rlfp_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? ram_data : '0;

endmodule

// File: sv/rlfp_ctrl.sv
// ----------------------------------------------------------------------------
// rlfp_ctrl
// Request sequencer: reads a slot row, modifies it and writes it back, one
// request at a time; keeps the latest-frame pointer and the global counters.
// ----------------------------------------------------------------------------
module rlfp_ctrl import rlfp_pkg::*; #(
	parameter int MAX_SLOTS   = 8,
	parameter int LENGTH_BITS = 24,
	localparam int AW = $clog2(MAX_SLOTS),
	localparam int RW = LENGTH_BITS + SEQ_W + CNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic [CFG_W-1:0] slots_in_use,
	output logic             mem_rd_en,
	output logic [AW-1:0]    mem_rd_addr,
	output logic             mem_wr_en,
	output logic [AW-1:0]    mem_wr_addr,
	output logic [RW-1:0]    mem_wr_data,
	input  logic [RW-1:0]    mem_rd_data,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	ctrl_state_t state_q, state_d;

	req_t                   req_q;
	logic [AW-1:0]          scan_q;
	logic [AW-1:0]          prev_q;
	status_t                st_q;
	logic [SLOT_W-1:0]      gslot_q;
	logic [SEQ_W-1:0]       gseq_q;
	logic [LEN_W-1:0]       glen_q;
	logic [AW-1:0]          latest_q;
	logic                   latest_valid_q;
	logic [SEQ_W-1:0]       pub_q;
	logic [SEQ_W-1:0]       drop_q;

	logic [CMP_W-1:0]       n_eff;
	logic [AW-1:0]          slot_addr;
	logic                   slot_bad;
	logic                   scan_last;
	logic [CNT_W-1:0]       rd_cnt;
	logic [SEQ_W-1:0]       rd_seq;
	logic [LENGTH_BITS-1:0] rd_len;
	logic [LENGTH_BITS-1:0] len_in;
	logic                   seq_differs;

	// effective slot count, clamped into [2, MAX_SLOTS]
	always_comb begin
		if (CMP_W'(slots_in_use) < MIN_SLOTS) begin
			n_eff = MIN_SLOTS;
		end else if (CMP_W'(slots_in_use) > CMP_W'(MAX_SLOTS)) begin
			n_eff = CMP_W'(MAX_SLOTS);
		end else begin
			n_eff = CMP_W'(slots_in_use);
		end
	end

	assign slot_addr   = AW'(req_q.slot);
	assign slot_bad    = CMP_W'(req_q.slot) >= n_eff;
	assign scan_last   = (CMP_W'(scan_q) + CMP_W'(1)) >= n_eff;
	assign rd_cnt      = mem_rd_data[RW-1 -: CNT_W];
	assign rd_seq      = mem_rd_data[LENGTH_BITS +: SEQ_W];
	assign rd_len      = mem_rd_data[LENGTH_BITS-1:0];
	assign len_in      = LENGTH_BITS'(req_q.frame_length);
	assign seq_differs = rd_seq != req_q.reader_last_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (req_q.action)
					ACT_ACQ_WR: begin
						mem_rd_en = 1'b1;
						state_d   = S_SCAN;
					end
					ACT_PUBLISH: begin
						if (slot_bad) begin
							state_d = S_DONE;
						end else begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = slot_addr;
							state_d     = S_PUB_WR;
						end
					end
					ACT_ACQ_LATEST: begin
						if (!latest_valid_q) begin
							state_d = S_DONE;
						end else begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = latest_q;
							state_d     = S_LAT_WR;
						end
					end
					ACT_RELEASE: begin
						if (slot_bad) begin
							state_d = S_DONE;
						end else begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = slot_addr;
							state_d     = S_REL_WR;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				// check the row read last cycle, fetch the next one meanwhile
				if (rd_cnt == '0) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = scan_q;
					mem_wr_data = {CNT_W'(1), rd_seq, rd_len};
					state_d     = S_DONE;
				end else if (scan_last) begin
					state_d = S_DONE;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = scan_q + AW'(1);
				end
			end
			S_PUB_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_addr;
				mem_wr_data = {rd_cnt, pub_q + SEQ_W'(1), len_in};
				state_d     = latest_valid_q ? S_PUB_RD_PREV : S_DONE;
			end
			S_PUB_RD_PREV: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = prev_q;
				state_d     = S_PUB_DEC;
			end
			S_PUB_DEC: begin
				if (rd_cnt != '0) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = prev_q;
					mem_wr_data = {rd_cnt - CNT_W'(1), rd_seq, rd_len};
				end
				state_d = S_DONE;
			end
			S_LAT_WR: begin
				if (seq_differs && rd_cnt != CNT_MAX) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = latest_q;
					mem_wr_data = {rd_cnt + CNT_W'(1), rd_seq, rd_len};
				end
				state_d = S_DONE;
			end
			S_REL_WR: begin
				if (rd_cnt != '0) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = slot_addr;
					mem_wr_data = {rd_cnt - CNT_W'(1), rd_seq, rd_len};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// pool-wide state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q       <= '0;
			latest_valid_q <= 1'b0;
			pub_q          <= '0;
			drop_q         <= '0;
		end else begin
			if (state_q == S_PUB_WR) begin
				pub_q          <= pub_q + SEQ_W'(1);
				latest_q       <= slot_addr;
				latest_valid_q <= 1'b1;
			end
			if (state_q == S_SCAN && rd_cnt != '0 && scan_last) begin
				drop_q <= drop_q + SEQ_W'(1);
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q   <= req;
				st_q    <= STAT_OK;
				gslot_q <= '0;
				gseq_q  <= '0;
				glen_q  <= '0;
			end
			S_DISPATCH: begin
				scan_q <= '0;
				if ((req_q.action == ACT_PUBLISH || req_q.action == ACT_RELEASE)
						&& slot_bad) begin
					st_q <= STAT_BAD_SLOT;
				end
				if (req_q.action == ACT_ACQ_LATEST && !latest_valid_q) begin
					st_q <= STAT_NONE;
				end
			end
			S_SCAN: begin
				if (rd_cnt == '0) begin
					gslot_q <= SLOT_W'(scan_q);
				end else if (scan_last) begin
					st_q <= STAT_NONE;
				end else begin
					scan_q <= scan_q + AW'(1);
				end
			end
			S_PUB_WR: begin
				prev_q <= latest_q;
				gseq_q <= pub_q + SEQ_W'(1);
				glen_q <= LEN_W'(len_in);
			end
			S_LAT_WR: begin
				if (seq_differs) begin
					gslot_q <= SLOT_W'(latest_q);
					gseq_q  <= rd_seq;
					glen_q  <= LEN_W'(rd_len);
				end else begin
					st_q <= STAT_NONE;
				end
			end
			default: ;
		endcase
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;

	always_comb begin
		res.status         = st_q;
		res.granted_slot   = gslot_q;
		res.granted_seq    = gseq_q;
		res.granted_length = glen_q;
		res.total_seq      = pub_q;
		res.drop_count     = drop_q;
	end

endmodule

// File: sv/refcounted_latest_frame_pool_unit.sv
// ----------------------------------------------------------------------------
// refcounted_latest_frame_pool_unit
// Reference-counted pool of frame slots with a latest-frame pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (action, slot, frame_length,
//   reader_last_seq); one result per request leaves on the m_ stream with
//   status, granted slot/sequence/length and both global counters.
//   cfg_wr_en/cfg_wr_data set slots_in_use; write it only while idle.
//   One request is worked on at a time, through a read-modify-write of the
//   slot-table RAM (one row per slot, one read and one write port).
//   Acquire-latest and release read the row at dispatch, then update it;
//   publish writes its row, then releases the previous latest frame when
//   there is one; acquire-writable scans the rows from slot 0 onwards
//   (one slot per cycle, at most the effective slot count); a request
//   refused at dispatch (slot out of use, no latest frame) goes to the result.
//   The next request is accepted the cycle after the result is loaded into
//   the output register, even while that result still waits for m_tready;
//   a further result waits in the sequencer until the register frees.
//   Reset empties the pool: all counts, sequences and lengths read as zero,
//   no latest frame, counters zero, slots_in_use 8. No clearing pass.
// ----------------------------------------------------------------------------
module refcounted_latest_frame_pool_unit import rlfp_pkg::*; #(
	parameter int MAX_SLOTS   = 8,
	parameter int LENGTH_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,     // action, slot, frame_length, reader_last_seq
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [127:0]     m_tdata,     // status, granted_slot, granted_seq,
	                                      // granted_length, total_seq, drop_count
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int RW = LENGTH_BITS + SEQ_W + CNT_W;

	logic [CFG_W-1:0] slots_q;
	logic             m_tvalid_q;
	result_t          out_q;
	result_t          res;
	logic             res_valid;
	logic             res_ready;
	req_t             req;

	logic             mem_rd_en;
	logic [AW-1:0]    mem_rd_addr;
	logic             mem_wr_en;
	logic [AW-1:0]    mem_wr_addr;
	logic [RW-1:0]    mem_wr_data;
	logic [RW-1:0]    mem_rd_data;

	assign req = req_t'(s_tdata[REQ_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
		end else if (cfg_wr_en) begin
			slots_q <= cfg_wr_data;
		end
	end

	rlfp_ctrl #(
		.MAX_SLOTS  (MAX_SLOTS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req         (req),
		.slots_in_use(slots_q),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_data (mem_rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	rlfp_store #(
		.WIDTH(RW),
		.DEPTH(MAX_SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// output register: load when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(128 - RES_W)'(0), out_q};

endmodule
